### hdl/vggce_pkg.sv
// ============================================================================
// Grain growth claim engine package
// Shared transaction types, action codes, register indexes and hash constants.
// ============================================================================
package vggce_pkg;

   typedef enum logic [2:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_LOAD   = 3'd2,
      ACT_CLAIM  = 3'd3,
      ACT_APPLY  = 3'd4,
      ACT_CLEAR  = 3'd5,
      ACT_FILL   = 3'd6,
      ACT_UNUSED = 3'd7
   } action_type;

   localparam logic [1:0] CSR_RNG_SEED    = 2'd0;
   localparam logic [1:0] CSR_WRAP_EDGES  = 2'd1;
   localparam logic [1:0] CSR_EDGE_LENGTH = 2'd2;

   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   localparam logic [4:0] SLOT_CENTRE = 5'd13;
   localparam logic [4:0] SLOT_LAST   = 5'd26;
   localparam logic [4:0] SLOT_DONE   = 5'd27;

   localparam logic [48:0] PROB_ONE   = 49'h1_0000_0000_0000;
   localparam logic [48:0] PROB_FLOOR = 49'd282;

   localparam logic [63:0] HASH_C1 = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] HASH_C2 = 64'h517cc1b727220a95;
   localparam logic [63:0] HASH_C3 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] HASH_C4 = 64'h94d049bb133111eb;

   typedef struct packed {
      logic [30:0] rng_seed;
      logic        wrap_edges;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic        in_grid;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic [4:0]  cell_z;
      logic [15:0] grain_value;
      logic [4:0]  prob_slot;
      logic [48:0] prob_value;
      logic [31:0] iteration;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  out_x;
      logic [4:0]  out_y;
      logic [4:0]  out_z;
      logic        keep_active;
      logic [15:0] grain_read;
      logic        last;
   } rsp_type;

endpackage

### hdl/voxel_grain_growth_claim_engine.sv
// ============================================================================
// Voxel grain growth claim engine
// Voxel and claim grids with per-cell write, read, claim, apply, clear and fill actions.
// ============================================================================
// Request transactions enter through req_push and req_full; each one yields
// one status transaction on the rsp_ channel, which apply precedes with one
// transaction for every captured neighbour. rsp_last marks the final one.
// Registers are written through csr_valid, csr_ready, csr_index and csr_data,
// and csr_ready is always high; write them only while the block is idle.
// An item leaves the front queue when the back end is idle; a load or an
// ignored item then passes the decode and status states, and a write or read
// passes decode, centre and status, before its status transaction is queued.
// Clear visits each neighbour in the neighbour state, apply and fill add a
// check state per neighbour, and apply a capture state for each captured
// neighbour; claim adds two hash states per rolled neighbour, where the two
// splitmix multiplications go through one shared 32 by 32 multiplier.
// After reset a clearing pass writes zero into all 2^(3*clog2(GRID_EDGE))
// entries of both grids (32768 by default), one entry per cycle; req_full
// stays high meanwhile. When the receiver stalls, results wait in a
// four-entry queue and the back end then holds until space returns.
// ============================================================================
module voxel_grain_growth_claim_engine
   import vggce_pkg::*;
#(
   parameter int GRID_EDGE  = 32,
   parameter int GRAIN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic [4:0]  req_cell_z,
   input  logic [15:0] req_grain_value,
   input  logic [4:0]  req_prob_slot,
   input  logic [48:0] req_prob_value,
   input  logic [31:0] req_iteration,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [4:0]  rsp_out_x,
   output logic [4:0]  rsp_out_y,
   output logic [4:0]  rsp_out_z,
   output logic        rsp_keep_active,
   output logic [15:0] rsp_grain_read,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);

   localparam int NW = $clog2(GRID_EDGE + 1);
   localparam int EW = (NW > 6) ? NW : 6;

   cfg_type                   cfg_ff;
   logic [5:0]                edge_ff;
   logic [NW-1:0]             edge_n;
   logic                      clearing;
   logic                      q_pop;
   logic                      q_empty;
   item_type                  q_item;
   logic                      rsp_push;
   rsp_type                   rsp_item;
   logic                      rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_rdata;
   rsp_type                   rsp_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rng_seed   <= '0;
         cfg_ff.wrap_edges <= 1'b1;
         edge_ff           <= 6'd32;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RNG_SEED:    cfg_ff.rng_seed   <= csr_data;
            CSR_WRAP_EDGES:  cfg_ff.wrap_edges <= csr_data[0];
            CSR_EDGE_LENGTH: edge_ff           <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (edge_ff == '0) begin
         edge_n = NW'(1);
      end else if (EW'(edge_ff) > EW'(GRID_EDGE)) begin
         edge_n = NW'(GRID_EDGE);
      end else begin
         edge_n = NW'(edge_ff);
      end
   end

   vggce_front #(
      .GRID_EDGE(GRID_EDGE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_action     (req_action),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_z     (req_cell_z),
      .req_grain_value(req_grain_value),
      .req_prob_slot  (req_prob_slot),
      .req_prob_value (req_prob_value),
      .req_iteration  (req_iteration),
      .hold           (clearing),
      .edge_n         (edge_n),
      .q_pop          (q_pop),
      .q_empty        (q_empty),
      .q_item         (q_item)
   );

   vggce_back #(
      .GRID_EDGE (GRID_EDGE),
      .GRAIN_BITS(GRAIN_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .edge_n  (edge_n),
      .q_empty (q_empty),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_full(rsp_full),
      .rsp_push(rsp_push),
      .rsp_item(rsp_item),
      .clearing(clearing)
   );

   vggce_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(4)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .wdata(rsp_item),
      .full (rsp_full),
      .pop  (rsp_pop),
      .rdata(rsp_rdata),
      .empty(rsp_empty)
   );

   assign rsp_head        = rsp_type'(rsp_rdata);
   assign rsp_kind        = rsp_head.kind;
   assign rsp_out_x       = rsp_head.out_x;
   assign rsp_out_y       = rsp_head.out_y;
   assign rsp_out_z       = rsp_head.out_z;
   assign rsp_keep_active = rsp_head.keep_active;
   assign rsp_grain_read  = rsp_head.grain_read;
   assign rsp_last        = rsp_head.last;

endmodule

### hdl/vggce_fifo.sv
// ============================================================================
// Grain growth claim engine queue
// Small register queue with a registered count, used between the parts.
// ============================================================================
module vggce_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ff;
   logic [PW-1:0]    rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= wdata;
      end
   end

endmodule

### hdl/vggce_mul64.sv
// ============================================================================
// Grain growth claim engine multiplier
// Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
// ============================================================================
module vggce_mul64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] p
);

   logic [63:0] a_ff;
   logic [63:0] b_ff;
   logic [63:0] prod_ff;
   logic [63:0] lo_ff;
   logic [31:0] hi_ff;
   logic [1:0]  step_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [31:0] op_a;
   logic [31:0] op_b;

   always_comb begin
      case (step_ff)
         2'd0: begin
            op_a = a_ff[31:0];
            op_b = b_ff[31:0];
         end
         2'd1: begin
            op_a = a_ff[31:0];
            op_b = b_ff[63:32];
         end
         default: begin
            op_a = a_ff[63:32];
            op_b = b_ff[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= 2'(step_ff + 1'b1);
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      prod_ff <= op_a * op_b;
      case (step_ff)
         2'd1:    lo_ff <= prod_ff;
         2'd2:    hi_ff <= prod_ff[31:0];
         2'd3:    hi_ff <= hi_ff + prod_ff[31:0];
         default: ;
      endcase
   end

   assign done = done_ff;
   assign p    = lo_ff + {hi_ff, 32'b0};

endmodule

### hdl/vggce_front.sv
// ============================================================================
// Grain growth claim engine front end
// Accepts request transactions, classifies them and queues them.
// ============================================================================
module vggce_front
   import vggce_pkg::*;
#(
   parameter int GRID_EDGE = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [2:0]                       req_action,
   input  logic [4:0]                       req_cell_x,
   input  logic [4:0]                       req_cell_y,
   input  logic [4:0]                       req_cell_z,
   input  logic [15:0]                      req_grain_value,
   input  logic [4:0]                       req_prob_slot,
   input  logic [48:0]                      req_prob_value,
   input  logic [31:0]                      req_iteration,
   input  logic                             hold,
   input  logic [$clog2(GRID_EDGE+1)-1:0]   edge_n,
   input  logic                             q_pop,
   output logic                             q_empty,
   output item_type                         q_item
);

   localparam int NW = $clog2(GRID_EDGE + 1);
   localparam int CMP_W = (NW > 5) ? NW : 5;

   item_type                    item;
   logic                        q_full;
   logic [$bits(item_type)-1:0] q_rdata;

   always_comb begin
      item.action      = action_type'(req_action);
      item.in_grid     = (CMP_W'(req_cell_x) < CMP_W'(edge_n)) &&
                         (CMP_W'(req_cell_y) < CMP_W'(edge_n)) &&
                         (CMP_W'(req_cell_z) < CMP_W'(edge_n));
      item.cell_x      = req_cell_x;
      item.cell_y      = req_cell_y;
      item.cell_z      = req_cell_z;
      item.grain_value = req_grain_value;
      item.prob_slot   = req_prob_slot;
      item.prob_value  = req_prob_value;
      item.iteration   = req_iteration;
   end

   assign req_full = q_full || hold;

   vggce_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(2)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (req_push && !req_full),
      .wdata(item),
      .full (q_full),
      .pop  (q_pop),
      .rdata(q_rdata),
      .empty(q_empty)
   );

   assign q_item = item_type'(q_rdata);

endmodule

### hdl/vggce_back.sv
// ============================================================================
// Grain growth claim engine back end
// Holds the grids and probabilities, executes each action and walks the neighbours of claim, apply, clear and fill.
// ============================================================================
module vggce_back
   import vggce_pkg::*;
#(
   parameter int GRID_EDGE  = 32,
   parameter int GRAIN_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic [$clog2(GRID_EDGE+1)-1:0] edge_n,
   input  logic                           q_empty,
   input  item_type                       q_item,
   output logic                           q_pop,
   input  logic                           rsp_full,
   output logic                           rsp_push,
   output rsp_type                        rsp_item,
   output logic                           clearing
);

   localparam int CW = $clog2(GRID_EDGE);
   localparam int NW = $clog2(GRID_EDGE + 1);
   localparam int AW = 3 * CW;
   localparam int CALC_W = ((NW > CW) ? NW : CW) + 1;

   typedef enum logic [11:0] {
      S_CLEAR   = 12'b0000_0000_0001,
      S_IDLE    = 12'b0000_0000_0010,
      S_DECODE  = 12'b0000_0000_0100,
      S_CENTER  = 12'b0000_0000_1000,
      S_BASE    = 12'b0000_0001_0000,
      S_NB      = 12'b0000_0010_0000,
      S_CHECK   = 12'b0000_0100_0000,
      S_HASH1   = 12'b0000_1000_0000,
      S_HASH2   = 12'b0001_0000_0000,
      S_CAPTURE = 12'b0010_0000_0000,
      S_STATUS  = 12'b0100_0000_0000,
      S_SPARE   = 12'b1000_0000_0000
   } state_type;

   function automatic logic [CW:0] nb_axis(input logic [CW-1:0] p, input logic [1:0] d,
                                           input logic [NW-1:0] n, input logic wrap);
      logic [CALC_W-1:0] pe;
      logic [CALC_W-1:0] ne;
      logic              ok;
      logic [CW-1:0]     c;
      pe = CALC_W'(p);
      ne = CALC_W'(n);
      ok = 1'b1;
      c  = p;
      case (d)
         OFF_MINUS: begin
            if (pe == '0) begin
               ok = wrap;
               c  = CW'(ne - 1'b1);
            end else begin
               c = CW'(pe - 1'b1);
            end
         end
         OFF_PLUS: begin
            if (CALC_W'(pe + 1'b1) >= ne) begin
               ok = wrap;
               c  = '0;
            end else begin
               c = CW'(pe + 1'b1);
            end
         end
         default: c = p;
      endcase
      return {ok, c};
   endfunction

   logic [GRAIN_BITS-1:0] vox_mem [2**AW];
   logic [GRAIN_BITS-1:0] clm_mem [2**AW];
   logic [48:0]           prob_ff [27];

   state_type             state_ff, state_in;
   item_type              item_ff, item_in;
   logic [GRAIN_BITS-1:0] gid_ff, gid_in;
   logic                  keep_ff, keep_in;
   logic [GRAIN_BITS-1:0] grain_ff, grain_in;
   logic [4:0]            slot_ff, slot_in;
   logic [1:0]            dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [CW-1:0]         cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [48:0]           psel_ff, psel_in;
   logic [63:0]           kc_ff, kc_in;
   logic [63:0]           base_ff, base_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [GRAIN_BITS-1:0] vox_rd_ff, clm_rd_ff;

   logic                  vox_we, vox_re, clm_we, clm_re;
   logic [AW-1:0]         vox_waddr, vox_raddr, clm_waddr, clm_raddr;
   logic [GRAIN_BITS-1:0] vox_wdata, clm_wdata;
   logic                  prob_we;

   logic                  mul_start, mul_done;
   logic [63:0]           mul_a, mul_b, mul_p;
   logic [63:0]           h0, hf;

   logic [CW-1:0]         ccx, ccy, ccz;
   logic [AW-1:0]         centre_addr, nb_addr_now, nb_addr_ff;
   logic [CW:0]           ax, ay, az;
   logic                  nb_ok;
   logic [4:0]            kidx;
   logic [4:0]            slot_adv;
   logic [1:0]            dx_adv, dy_adv, dz_adv;
   logic [48:0]           prob_sat;

   assign ccx         = CW'(item_ff.cell_x);
   assign ccy         = CW'(item_ff.cell_y);
   assign ccz         = CW'(item_ff.cell_z);
   assign centre_addr = {ccx, ccy, ccz};
   assign ax          = nb_axis(ccx, dx_ff, edge_n, cfg.wrap_edges);
   assign ay          = nb_axis(ccy, dy_ff, edge_n, cfg.wrap_edges);
   assign az          = nb_axis(ccz, dz_ff, edge_n, cfg.wrap_edges);
   assign nb_ok       = ax[CW] && ay[CW] && az[CW];
   assign nb_addr_now = {ax[CW-1:0], ay[CW-1:0], az[CW-1:0]};
   assign nb_addr_ff  = {cx_ff, cy_ff, cz_ff};
   assign kidx        = (slot_ff > SLOT_CENTRE) ? 5'(slot_ff - 1'b1) : slot_ff;
   assign h0          = base_ff ^ kc_ff;
   assign hf          = mul_p ^ (mul_p >> 31);
   assign prob_sat    = (item_ff.prob_value > PROB_ONE) ? PROB_ONE : item_ff.prob_value;
   assign clearing    = (state_ff == S_CLEAR);

   always_comb begin
      slot_adv = 5'(slot_ff + 1'b1);
      dx_adv   = dx_ff;
      dy_adv   = dy_ff;
      dz_adv   = 2'(dz_ff + 1'b1);
      if (slot_ff == 5'(SLOT_CENTRE - 1'b1)) begin
         slot_adv = 5'(slot_ff + 2'd2);
         dz_adv   = OFF_PLUS;
      end else if (dz_ff == OFF_PLUS) begin
         dz_adv = OFF_MINUS;
         if (dy_ff == OFF_PLUS) begin
            dy_adv = OFF_MINUS;
            dx_adv = 2'(dx_ff + 1'b1);
         end else begin
            dy_adv = 2'(dy_ff + 1'b1);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      gid_in    = gid_ff;
      keep_in   = keep_ff;
      grain_in  = grain_ff;
      slot_in   = slot_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      psel_in   = psel_ff;
      kc_in     = kc_ff;
      base_in   = base_ff;
      clr_in    = clr_ff;
      vox_we    = 1'b0;
      vox_re    = 1'b0;
      clm_we    = 1'b0;
      clm_re    = 1'b0;
      vox_waddr = nb_addr_ff;
      vox_raddr = nb_addr_now;
      clm_waddr = nb_addr_ff;
      clm_raddr = nb_addr_now;
      vox_wdata = '0;
      clm_wdata = '0;
      prob_we   = 1'b0;
      mul_start = 1'b0;
      mul_a     = 64'(item_ff.iteration);
      mul_b     = HASH_C1;
      q_pop     = 1'b0;
      rsp_push  = 1'b0;
      rsp_item  = '{kind: 1'b0, out_x: item_ff.cell_x, out_y: item_ff.cell_y,
                    out_z: item_ff.cell_z, keep_active: keep_ff,
                    grain_read: 16'(grain_ff), last: 1'b1};
      case (state_ff)
         S_CLEAR: begin
            vox_we    = 1'b1;
            clm_we    = 1'b1;
            vox_waddr = clr_ff;
            clm_waddr = clr_ff;
            clr_in    = AW'(clr_ff + 1'b1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            keep_in  = 1'b0;
            grain_in = '0;
            slot_in  = '0;
            dx_in    = OFF_MINUS;
            dy_in    = OFF_MINUS;
            dz_in    = OFF_MINUS;
            if (item_ff.action == ACT_LOAD) begin
               prob_we  = (item_ff.prob_slot <= SLOT_LAST);
               state_in = S_STATUS;
            end else if (!item_ff.in_grid || item_ff.action == ACT_UNUSED) begin
               state_in = S_STATUS;
            end else begin
               vox_re    = 1'b1;
               vox_raddr = centre_addr;
               state_in  = S_CENTER;
            end
         end
         S_CENTER: begin
            gid_in = vox_rd_ff;
            case (item_ff.action)
               ACT_WRITE: begin
                  vox_we    = 1'b1;
                  vox_waddr = centre_addr;
                  vox_wdata = GRAIN_BITS'(item_ff.grain_value);
                  state_in  = S_STATUS;
               end
               ACT_READ: begin
                  grain_in = vox_rd_ff;
                  state_in = S_STATUS;
               end
               ACT_CLAIM: begin
                  mul_start = 1'b1;
                  state_in  = S_BASE;
               end
               ACT_APPLY, ACT_CLEAR: state_in = S_NB;
               ACT_FILL: state_in = (vox_rd_ff == '0) ? S_NB : S_STATUS;
               default: state_in = S_STATUS;
            endcase
         end
         S_BASE: begin
            if (mul_done) begin
               base_in = 64'(cfg.rng_seed) ^ mul_p ^
                         (64'(item_ff.cell_x) + (64'(item_ff.cell_y) << 10) +
                          (64'(item_ff.cell_z) << 20));
               state_in = S_NB;
            end
         end
         S_NB: begin
            if (slot_ff == SLOT_DONE) begin
               state_in = S_STATUS;
            end else if (!nb_ok || item_ff.action == ACT_CLEAR) begin
               clm_we    = nb_ok;
               clm_waddr = nb_addr_now;
               slot_in   = slot_adv;
               dx_in     = dx_adv;
               dy_in     = dy_adv;
               dz_in     = dz_adv;
            end else begin
               vox_re   = 1'b1;
               clm_re   = 1'b1;
               cx_in    = ax[CW-1:0];
               cy_in    = ay[CW-1:0];
               cz_in    = az[CW-1:0];
               psel_in  = prob_ff[slot_ff];
               kc_in    = 64'(kidx) * HASH_C2;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_NB;
            slot_in  = slot_adv;
            dx_in    = dx_adv;
            dy_in    = dy_adv;
            dz_in    = dz_adv;
            case (item_ff.action)
               ACT_CLAIM: begin
                  if (vox_rd_ff == '0 && psel_ff >= PROB_FLOOR) begin
                     mul_start = 1'b1;
                     mul_a     = h0 ^ (h0 >> 30);
                     mul_b     = HASH_C3;
                     slot_in   = slot_ff;
                     dx_in     = dx_ff;
                     dy_in     = dy_ff;
                     dz_in     = dz_ff;
                     state_in  = S_HASH1;
                  end
               end
               ACT_APPLY: begin
                  if (vox_rd_ff == '0) begin
                     if (clm_rd_ff == '0) begin
                        keep_in = 1'b1;
                     end else if (clm_rd_ff == gid_ff) begin
                        vox_we    = 1'b1;
                        vox_wdata = clm_rd_ff;
                        slot_in   = slot_ff;
                        dx_in     = dx_ff;
                        dy_in     = dy_ff;
                        dz_in     = dz_ff;
                        state_in  = S_CAPTURE;
                     end
                  end
               end
               default: begin
                  if (vox_rd_ff != '0) begin
                     vox_we    = 1'b1;
                     vox_waddr = centre_addr;
                     vox_wdata = vox_rd_ff;
                     keep_in   = 1'b1;
                     grain_in  = vox_rd_ff;
                     state_in  = S_STATUS;
                  end
               end
            endcase
         end
         S_HASH1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_p ^ (mul_p >> 27);
               mul_b     = HASH_C4;
               state_in  = S_HASH2;
            end
         end
         S_HASH2: begin
            if (mul_done) begin
               if ({1'b0, hf[47:0]} < psel_ff &&
                   (clm_rd_ff == '0 || gid_ff < clm_rd_ff)) begin
                  clm_we    = 1'b1;
                  clm_wdata = gid_ff;
               end
               slot_in  = slot_adv;
               dx_in    = dx_adv;
               dy_in    = dy_adv;
               dz_in    = dz_adv;
               state_in = S_NB;
            end
         end
         S_CAPTURE: begin
            rsp_item = '{kind: 1'b1, out_x: 5'(cx_ff), out_y: 5'(cy_ff), out_z: 5'(cz_ff),
                         keep_active: 1'b0, grain_read: 16'(clm_rd_ff), last: 1'b0};
            if (!rsp_full) begin
               rsp_push = 1'b1;
               slot_in  = slot_adv;
               dx_in    = dx_adv;
               dy_in    = dy_adv;
               dz_in    = dz_adv;
               state_in = S_NB;
            end
         end
         S_STATUS: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      gid_ff   <= gid_in;
      keep_ff  <= keep_in;
      grain_ff <= grain_in;
      slot_ff  <= slot_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      psel_ff  <= psel_in;
      kc_ff    <= kc_in;
      base_ff  <= base_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 27; i++) begin
            prob_ff[i] <= '0;
         end
      end else if (prob_we) begin
         prob_ff[item_ff.prob_slot] <= prob_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (vox_we) begin
         vox_mem[vox_waddr] <= vox_wdata;
      end
      if (vox_re) begin
         vox_rd_ff <= vox_mem[vox_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (clm_we) begin
         clm_mem[clm_waddr] <= clm_wdata;
      end
      if (clm_re) begin
         clm_rd_ff <= clm_mem[clm_raddr];
      end
   end

   vggce_mul64 u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .a    (mul_a),
      .b    (mul_b),
      .done (mul_done),
      .p    (mul_p)
   );

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full) else $error("result pushed into a full queue");
   a_centre_skipped: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NB |-> slot_ff != SLOT_CENTRE) else $error("centre slot visited");
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_BASE || state_ff == S_HASH1 || state_ff == S_HASH2))
      else $error("unexpected multiplier completion");
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !q_pop) else $error("item taken during clearing pass");
`endif

endmodule

### verif/vggce_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Grain growth claim engine checker
// Watches the request, result and register channels, keeps its own copy of
// the voxel grid, claim grid, probabilities and registers, predicts the
// result transactions of every accepted request and compares them in order.
// ============================================================================
module vggce_checker
   import vggce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic [4:0]  req_cell_z,
   input  logic [15:0] req_grain_value,
   input  logic [4:0]  req_prob_slot,
   input  logic [48:0] req_prob_value,
   input  logic [31:0] req_iteration,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_kind,
   input  logic [4:0]  rsp_out_x,
   input  logic [4:0]  rsp_out_y,
   input  logic [4:0]  rsp_out_z,
   input  logic        rsp_keep_active,
   input  logic [15:0] rsp_grain_read,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data,
   output int          errors,
   output int          pending,
   output int          checked
);

   localparam int EDGE = 32;

   logic [15:0] voxels [0:EDGE*EDGE*EDGE-1];
   logic [15:0] claims [0:EDGE*EDGE*EDGE-1];
   logic [48:0] probs  [0:26];
   logic [30:0] seed;
   logic        wrap;
   logic [5:0]  edge_len;
   rsp_type     expected_q[$];

   function automatic int cell_at(int x, int y, int z);
      return (x * EDGE + y) * EDGE + z;
   endfunction

   function automatic int slot_for(int k);
      return (k < SLOT_CENTRE) ? k : k + 1;
   endfunction

   function automatic bit neighbour_at(int n, int x, int y, int z, int k,
                                       output int cx, output int cy, output int cz);
      int s;
      int d[3];
      int p[3];
      int c[3];
      s = slot_for(k);
      d[0] = s / 9;
      d[1] = (s / 3) % 3;
      d[2] = s % 3;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      for (int i = 0; i < 3; i++) begin
         if (d[i] == OFF_MINUS) begin
            if (p[i] == 0) begin
               if (!wrap) return 0;
               c[i] = n - 1;
            end else begin
               c[i] = p[i] - 1;
            end
         end else if (d[i] == OFF_PLUS) begin
            if (p[i] + 1 >= n) begin
               if (!wrap) return 0;
               c[i] = 0;
            end else begin
               c[i] = p[i] + 1;
            end
         end else begin
            c[i] = p[i];
         end
      end
      cx = c[0];
      cy = c[1];
      cz = c[2];
      return 1;
   endfunction

   function automatic logic [47:0] roll_for(logic [31:0] iter, int x, int y, int z, int k);
      logic [63:0] h;
      h = {33'd0, seed};
      h ^= {32'd0, iter} * HASH_C1;
      h ^= 64'(x) + (64'(y) << 10) + (64'(z) << 20);
      h ^= 64'(k) * HASH_C2;
      h = (h ^ (h >> 30)) * HASH_C3;
      h = (h ^ (h >> 27)) * HASH_C4;
      h ^= (h >> 31);
      return h[47:0];
   endfunction

   function automatic rsp_type make_rsp(logic kind, int x, int y, int z, logic keep,
                                        logic [15:0] grain, logic last);
      rsp_type r;
      r.kind        = kind;
      r.out_x       = x[4:0];
      r.out_y       = y[4:0];
      r.out_z       = z[4:0];
      r.keep_active = keep;
      r.grain_read  = grain;
      r.last        = last;
      return r;
   endfunction

   task automatic predict_growth(action_type act, int x, int y, int z, logic [15:0] gval,
                                 int slot, logic [48:0] pval, logic [31:0] iter);
      int n;
      int idx;
      int ni;
      int cx;
      int cy;
      int cz;
      logic [15:0] gid;
      logic [15:0] w;
      logic [15:0] grain;
      logic [48:0] p;
      logic keep;
      bit filled;
      n = (edge_len < 1) ? 1 : (edge_len > EDGE) ? EDGE : edge_len;
      keep = 0;
      grain = '0;
      if (act == ACT_LOAD) begin
         if (slot <= SLOT_LAST) probs[slot] = (pval > PROB_ONE) ? PROB_ONE : pval;
      end else if (x < n && y < n && z < n && act != ACT_UNUSED) begin
         idx = cell_at(x, y, z);
         gid = voxels[idx];
         case (act)
            ACT_WRITE: voxels[idx] = gval;
            ACT_READ: grain = gid;
            ACT_CLAIM: begin
               for (int k = 0; k < 26; k++) begin
                  if (!neighbour_at(n, x, y, z, k, cx, cy, cz)) continue;
                  ni = cell_at(cx, cy, cz);
                  if (voxels[ni] != 0) continue;
                  p = probs[slot_for(k)];
                  if (p < PROB_FLOOR) continue;
                  if ({1'b0, roll_for(iter, x, y, z, k)} >= p) continue;
                  if (claims[ni] == 0 || gid < claims[ni]) claims[ni] = gid;
               end
            end
            ACT_APPLY: begin
               for (int k = 0; k < 26; k++) begin
                  if (!neighbour_at(n, x, y, z, k, cx, cy, cz)) continue;
                  ni = cell_at(cx, cy, cz);
                  if (voxels[ni] != 0) continue;
                  w = claims[ni];
                  if (w == 0) begin
                     keep = 1;
                  end else if (w == gid) begin
                     voxels[ni] = w;
                     expected_q = {expected_q, make_rsp(1'b1, cx, cy, cz, 1'b0, w, 1'b0)};
                  end
               end
            end
            ACT_CLEAR: begin
               for (int k = 0; k < 26; k++) begin
                  if (neighbour_at(n, x, y, z, k, cx, cy, cz)) claims[cell_at(cx, cy, cz)] = '0;
               end
            end
            ACT_FILL: begin
               filled = 0;
               if (gid == 0) begin
                  for (int k = 0; k < 26 && !filled; k++) begin
                     if (!neighbour_at(n, x, y, z, k, cx, cy, cz)) continue;
                     w = voxels[cell_at(cx, cy, cz)];
                     if (w != 0) begin
                        voxels[idx] = w;
                        keep = 1;
                        grain = w;
                        filled = 1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      expected_q = {expected_q, make_rsp(1'b0, x, y, z, keep, grain, 1'b1)};
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < EDGE * EDGE * EDGE; i++) begin
            voxels[i] = '0;
            claims[i] = '0;
         end
         for (int i = 0; i <= SLOT_LAST; i++) probs[i] = '0;
         seed = '0;
         wrap = 1'b1;
         edge_len = 6'd32;
         expected_q.delete();
         errors = 0;
         checked = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = make_rsp(rsp_kind, rsp_out_x, rsp_out_y, rsp_out_z, rsp_keep_active,
                           rsp_grain_read, rsp_last);
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("[%0t] unexpected result transaction %p", $time, got);
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("[%0t] result mismatch: expected %p, actual %p", $time, want, got);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RNG_SEED:    seed = csr_data;
               CSR_WRAP_EDGES:  wrap = csr_data[0];
               CSR_EDGE_LENGTH: edge_len = csr_data[5:0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            predict_growth(action_type'(req_action), req_cell_x, req_cell_y, req_cell_z,
                           req_grain_value, req_prob_slot, req_prob_value, req_iteration);
      end
      pending = expected_q.size();
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Grain growth claim engine testbench
// Directed actions at the grid corners and probability extremes, then rounds
// of writes, probability loads, claim, apply, clear and fill under a range of
// register settings and idling patterns, checked by the attached checker.
// ============================================================================
module tb_top;
   import vggce_pkg::*;

   localparam int WATCHDOG_LIMIT = 100000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_action;
   logic [4:0]  req_cell_x;
   logic [4:0]  req_cell_y;
   logic [4:0]  req_cell_z;
   logic [15:0] req_grain_value;
   logic [4:0]  req_prob_slot;
   logic [48:0] req_prob_value;
   logic [31:0] req_iteration;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_kind;
   logic [4:0]  rsp_out_x;
   logic [4:0]  rsp_out_y;
   logic [4:0]  rsp_out_z;
   logic        rsp_keep_active;
   logic [15:0] rsp_grain_read;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [30:0] csr_data;
   int          errors;
   int          pending;
   int          checked;
   int          sent;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles;
   int          edge_now;

   voxel_grain_growth_claim_engine u_top (.*);

   vggce_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) rsp_pop = ($urandom_range(99) >= stall_pct);

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic logic [48:0] pick_prob();
      case ($urandom_range(5))
         0: return PROB_ONE;
         1: return '0;
         2: return PROB_FLOOR - 1;
         3: return PROB_FLOOR;
         4: return 49'({$urandom, $urandom});
         default: return {1'b0, 16'($urandom_range(65535)), $urandom};
      endcase
   endfunction

   task automatic send(action_type act, int x, int y, int z, logic [15:0] gval,
                       int slot, logic [48:0] pval);
      while ($urandom_range(99) < idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push        = 1'b1;
      req_action      = act;
      req_cell_x      = x[4:0];
      req_cell_y      = y[4:0];
      req_cell_z      = z[4:0];
      req_grain_value = gval;
      req_prob_slot   = slot[4:0];
      req_prob_value  = pval;
      req_iteration   = $urandom;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic act_on(action_type act, int x, int y, int z);
      send(act, x, y, z, 16'($urandom), $urandom_range(31), 49'({$urandom, $urandom}));
   endtask

   task automatic write_csr(logic [1:0] index, logic [30:0] data);
      req_push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_registers(logic [30:0] seed, logic wrap, logic [5:0] len);
      write_csr(CSR_RNG_SEED, seed);
      write_csr(CSR_WRAP_EDGES, {30'd0, wrap});
      write_csr(CSR_EDGE_LENGTH, {25'd0, len});
      edge_now = (len < 1) ? 1 : (len > 32) ? 32 : len;
   endtask

   task automatic growth_round();
      int cx[3];
      int cy[3];
      int cz[3];
      int r;
      for (int i = 0; i < 3; i++) begin
         cx[i] = $urandom_range(edge_now - 1);
         cy[i] = $urandom_range(edge_now - 1);
         cz[i] = $urandom_range(edge_now - 1);
         r = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 5);
         send(ACT_WRITE, cx[i], cy[i], cz[i], r[15:0], $urandom_range(31), '0);
      end
      for (int i = 0; i < 4; i++)
         send(ACT_LOAD, $urandom_range(31), $urandom_range(31), $urandom_range(31),
              16'($urandom), $urandom_range(31), pick_prob());
      for (int i = 0; i < 3; i++) act_on(ACT_CLAIM, cx[i], cy[i], cz[i]);
      for (int i = 0; i < 3; i++) act_on(ACT_APPLY, cx[i], cy[i], cz[i]);
      for (int i = 0; i < 3; i++) act_on(ACT_CLEAR, cx[i], cy[i], cz[i]);
      for (int i = 0; i < 2; i++)
         act_on(ACT_FILL, $urandom_range(edge_now - 1), $urandom_range(edge_now - 1),
                $urandom_range(edge_now - 1));
      act_on(ACT_READ, cx[0], cy[0], cz[0]);
      for (int i = 0; i < 3; i++)
         act_on(action_type'($urandom_range(7)), $urandom_range(31), $urandom_range(31),
                $urandom_range(31));
   endtask

   initial begin
      logic [5:0] lengths[10];
      reset = 1'b1;
      req_push = 1'b0;
      req_action = ACT_READ;
      req_cell_x = '0;
      req_cell_y = '0;
      req_cell_z = '0;
      req_grain_value = '0;
      req_prob_slot = '0;
      req_prob_value = '0;
      req_iteration = '0;
      csr_valid = 1'b0;
      csr_index = CSR_RNG_SEED;
      csr_data = '0;
      sent = 0;
      idle_pct = 0;
      stall_pct = 0;
      edge_now = 32;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(ACT_WRITE, 31, 31, 31, 16'hFFFF, 0, '0);
      send(ACT_WRITE, 0, 0, 0, 16'd1, 0, '0);
      send(ACT_WRITE, 0, 1, 0, 16'd2, 0, '0);
      act_on(ACT_READ, 31, 31, 31);
      act_on(ACT_READ, 0, 0, 0);
      act_on(ACT_READ, 5, 5, 5);
      send(ACT_LOAD, 0, 0, 0, '0, 0, 49'h1_FFFF_FFFF_FFFF);
      send(ACT_LOAD, 0, 0, 0, '0, 4, PROB_ONE);
      send(ACT_LOAD, 0, 0, 0, '0, 22, PROB_FLOOR);
      send(ACT_LOAD, 0, 0, 0, '0, 26, PROB_FLOOR - 1);
      send(ACT_LOAD, 0, 0, 0, '0, 31, PROB_ONE);
      send(ACT_LOAD, 0, 0, 0, '0, 12, PROB_ONE);
      act_on(ACT_CLAIM, 0, 1, 0);
      act_on(ACT_CLAIM, 0, 0, 0);
      act_on(ACT_CLAIM, 5, 5, 5);
      act_on(ACT_APPLY, 0, 0, 0);
      act_on(ACT_APPLY, 0, 1, 0);
      act_on(ACT_CLEAR, 0, 0, 0);
      act_on(ACT_FILL, 30, 30, 30);
      act_on(ACT_FILL, 0, 0, 0);
      act_on(ACT_FILL, 10, 10, 10);
      act_on(ACT_UNUSED, 31, 0, 31);

      lengths = '{6'd4, 6'd1, 6'd0, 6'd3, 6'd63, 6'd5, 6'd2, 6'd32, 6'd6, 6'd4};
      for (int p = 0; p < 20; p++) begin
         req_push = 1'b0;
         idle_pct = 0;
         stall_pct = 0;
         if (p == 0)
            set_registers(31'h7FFF_FFFF, 1'b0, lengths[0]);
         else if (p == 1)
            set_registers('0, 1'b1, lengths[1]);
         else
            set_registers(31'($urandom), p[0], lengths[p % 10]);
         case (p % 4)
            1: idle_pct = 55;
            2: stall_pct = 55;
            3: begin
               idle_pct = 9;
               stall_pct = 9;
            end
            default: ;
         endcase
         growth_round();
      end

      req_push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("Sent %0d request transactions over 20 register settings and 4 idling patterns,",
               sent);
      $display("checked %0d result transactions.", checked);
      if (errors == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
hdl/vggce_pkg.sv
hdl/vggce_fifo.sv
hdl/vggce_mul64.sv
hdl/vggce_front.sv
hdl/vggce_back.sv
hdl/voxel_grain_growth_claim_engine.sv
verif/vggce_checker.sv
verif/tb_top.sv
